>>> rtl/v2dconv_pkg.sv
// Shared types and constants of the valid-region 2D convolution block.
`timescale 1ns / 1ps

package v2dconv_pkg;

   localparam int KERNEL_DIM     = 3;
   localparam int COEF_BITS      = 16;
   localparam int VALUE_BITS     = 40;
   localparam int ROW_BITS       = 16;
   localparam int OUT_COL_BITS   = 10;
   localparam int KSIZE_BITS     = 2;
   localparam int ROW_LEN_BITS   = 11;
   localparam int CSR_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [KSIZE_BITS-1:0]   KSIZE_RESET   = 2'd3;
   localparam logic [ROW_LEN_BITS-1:0] ROW_LEN_RESET = 11'd1024;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KERNEL_HEIGHT = 3'd0,
      CSR_KERNEL_WIDTH  = 3'd1,
      CSR_ROW_LENGTH    = 3'd2,
      CSR_KERNEL_ROW0   = 3'd3,
      CSR_KERNEL_ROW1   = 3'd4,
      CSR_KERNEL_ROW2   = 3'd5
   } csr_index_type;

   typedef logic [CSR_DATA_BITS-1:0] kernel_row_type;

   // Pick one signed Q4.12 coefficient out of a packed kernel row.
   function automatic logic signed [COEF_BITS-1:0] coef_select(
      input kernel_row_type   row,
      input logic [1:0]       col
   );
      logic signed [COEF_BITS-1:0] coef;
      case (col)
         2'd0:    coef = row[15:0];
         2'd1:    coef = row[31:16];
         2'd2:    coef = row[47:32];
         default: coef = '0;
      endcase
      return coef;
   endfunction

endpackage

>>> rtl/v2dconv_line_buf.sv
// Line store: two previous rows packed per column, with write-to-read bypass.
`timescale 1ns / 1ps

module v2dconv_line_buf #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;
   logic [WIDTH-1:0] byp_data_ff;
   logic             byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read that meets a write to the same column takes the new word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

>>> rtl/valid_2d_convolution.sv
// Top level of the valid-region 2D convolution (correlation) block.
`timescale 1ns / 1ps

// Usage
//   req_ channel: one signed sample per transaction in raster order;
//   req_last_sample marks the final sample of a frame and restarts the
//   row and column counters.
//   rsp_ channel: one transaction per sample once a full kernel footprint
//   has arrived, carrying the exact sum of products (Q.12 scaled), its
//   output row and column, and rsp_last_result on the frame's last result.
//   csr_ channel: register writes by index (kernel height, kernel width,
//   row length, three packed coefficient rows); always ready. Write only
//   while no transaction is in flight.
// Timing
//   One transaction per clock sustained while rsp_ready stays high. A
//   sample passes the input stage (line store read), the product stage
//   (window and multiply) and the output stage (nine-term adder) to rsp_.
// Reset
//   Counters, window and pipeline valids clear; registers take their
//   defaults (3x3 kernel, 1024-sample rows, zero coefficients). The line
//   store is not cleared, so no sweep follows reset.
// Back-pressure: a stalled rsp_ channel fills the output and product
//   stages, then the input stage, and only then drops req_ready.
module valid_2d_convolution #(
   parameter int MAX_ROW_LENGTH = 1024,
   parameter int SAMPLE_BITS    = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input samples
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample,
   input  logic                                    req_last_sample,
   // results
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [v2dconv_pkg::VALUE_BITS-1:0] rsp_value,
   output logic [v2dconv_pkg::ROW_BITS-1:0]        rsp_out_row,
   output logic [v2dconv_pkg::OUT_COL_BITS-1:0]    rsp_out_col,
   output logic                                    rsp_last_result,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [v2dconv_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [v2dconv_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int KD        = v2dconv_pkg::KERNEL_DIM;
   localparam int TAPS      = KD * KD;
   localparam int COL_BITS  = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_BITS  = $clog2(MAX_ROW_LENGTH + 1);
   localparam int CMP_BITS  = (LEN_BITS > v2dconv_pkg::ROW_LEN_BITS) ?
                              LEN_BITS : v2dconv_pkg::ROW_LEN_BITS;
   localparam int PROD_BITS = SAMPLE_BITS + v2dconv_pkg::COEF_BITS;
   localparam int VB        = v2dconv_pkg::VALUE_BITS;
   localparam int RB        = v2dconv_pkg::ROW_BITS;
   localparam int OCB       = v2dconv_pkg::OUT_COL_BITS;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [v2dconv_pkg::KSIZE_BITS-1:0]   kh_ff;
   logic [v2dconv_pkg::KSIZE_BITS-1:0]   kw_ff;
   logic [v2dconv_pkg::ROW_LEN_BITS-1:0] row_len_ff;
   v2dconv_pkg::kernel_row_type          krow_ff [KD];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kh_ff      <= v2dconv_pkg::KSIZE_RESET;
         kw_ff      <= v2dconv_pkg::KSIZE_RESET;
         row_len_ff <= v2dconv_pkg::ROW_LEN_RESET;
         for (int r = 0; r < KD; r++) begin
            krow_ff[r] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (v2dconv_pkg::csr_index_type'(csr_index))
            v2dconv_pkg::CSR_KERNEL_HEIGHT: kh_ff <= csr_wdata[1:0];
            v2dconv_pkg::CSR_KERNEL_WIDTH:  kw_ff <= csr_wdata[1:0];
            v2dconv_pkg::CSR_ROW_LENGTH:    row_len_ff <= csr_wdata[10:0];
            v2dconv_pkg::CSR_KERNEL_ROW0:   krow_ff[0] <= csr_wdata;
            v2dconv_pkg::CSR_KERNEL_ROW1:   krow_ff[1] <= csr_wdata;
            v2dconv_pkg::CSR_KERNEL_ROW2:   krow_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero kernel size counts as one; a zero row length counts as one,
   // and an oversized one saturates.
   logic [1:0]          kh_eff;
   logic [1:0]          kw_eff;
   logic [CMP_BITS-1:0] rl_ext;
   logic [CMP_BITS-1:0] rl_eff;

   assign kh_eff = (kh_ff == 2'd0) ? 2'd1 : kh_ff;
   assign kw_eff = (kw_ff == 2'd0) ? 2'd1 : kw_ff;
   assign rl_ext = CMP_BITS'(row_len_ff);

   always_comb begin
      if (rl_ext == '0) begin
         rl_eff = CMP_BITS'(1);
      end else if (rl_ext > CMP_BITS'(MAX_ROW_LENGTH)) begin
         rl_eff = CMP_BITS'(MAX_ROW_LENGTH);
      end else begin
         rl_eff = rl_ext;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline handshake
   // ---------------------------------------------------------------------
   logic req_accept;
   logic s1_valid_ff, s1_valid_in;
   logic s1_hit, s1_adv;
   logic p_valid_ff, p_valid_in;
   logic p_adv, p_free;
   logic out_valid_ff, out_valid_in;
   logic out_free;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign p_adv      = p_valid_ff && out_free;
   assign p_free     = !p_valid_ff || p_adv;
   // Samples that make no result leave the input stage without a slot.
   assign s1_adv     = s1_valid_ff && (!s1_hit || p_free);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign p_valid_in   = (s1_adv && s1_hit) ? 1'b1 : (p_adv ? 1'b0 : p_valid_ff);
   assign out_valid_in = p_adv ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Raster position counters, advanced on every accepted transaction
   // ---------------------------------------------------------------------
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [RB-1:0]       row_ff, row_in;
   logic [CMP_BITS-1:0] col_next;

   assign col_next = CMP_BITS'(col_ff) + CMP_BITS'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (req_last_sample) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= rl_eff) begin
            col_in = '0;
            row_in = row_ff + RB'(1);
         end else begin
            col_in = COL_BITS'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input stage: hold the sample and its position while the line store
   // word for its column is read
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          s1_last_ff;
   logic [COL_BITS-1:0]           s1_col_ff;
   logic [RB-1:0]                 s1_row_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_sample;
         s1_last_ff   <= req_last_sample;
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
      end
   end

   assign s1_hit = (s1_row_ff >= RB'(kh_eff - 2'd1)) &&
                   (s1_col_ff >= COL_BITS'(kw_eff - 2'd1));

   // Line store word: upper half is the older row, lower half the newer.
   logic [2*SAMPLE_BITS-1:0] line_rd;
   logic [2*SAMPLE_BITS-1:0] line_wr;

   assign line_wr = {line_rd[SAMPLE_BITS-1:0], s1_sample_ff};

   v2dconv_line_buf #(
      .DEPTH (MAX_ROW_LENGTH),
      .WIDTH (2 * SAMPLE_BITS)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   // ---------------------------------------------------------------------
   // Window: shift left, new column enters on the right
   // ---------------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] win_ff [KD][KD];
   logic signed [SAMPLE_BITS-1:0] win_in [KD][KD];
   logic signed [SAMPLE_BITS-1:0] new_col [KD];

   assign new_col[0] = line_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign new_col[1] = line_rd[SAMPLE_BITS-1:0];
   assign new_col[2] = s1_sample_ff;

   always_comb begin
      for (int r = 0; r < KD; r++) begin
         for (int q = 0; q < KD - 1; q++) begin
            win_in[r][q] = win_ff[r][q+1];
         end
         win_in[r][KD-1] = new_col[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KD; r++) begin
            for (int q = 0; q < KD; q++) begin
               win_ff[r][q] <= '0;
            end
         end
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   // ---------------------------------------------------------------------
   // Multiply: the kernel sits in the bottom-right corner of the window,
   // taking the top-left coefficients when it is smaller than 3x3
   // ---------------------------------------------------------------------
   logic signed [PROD_BITS-1:0] prod_in [TAPS];

   always_comb begin
      logic [1:0]                          ca;
      logic [1:0]                          cb;
      logic signed [v2dconv_pkg::COEF_BITS-1:0] coef;
      for (int i = 0; i < KD; i++) begin
         for (int j = 0; j < KD; j++) begin
            ca = 2'(i + int'(kh_eff) - KD);
            cb = 2'(j + int'(kw_eff) - KD);
            coef = v2dconv_pkg::coef_select(krow_ff[ca], cb);
            if ((i + int'(kh_eff) >= KD) && (j + int'(kw_eff) >= KD)) begin
               prod_in[i*KD+j] = PROD_BITS'(coef) * PROD_BITS'(win_in[i][j]);
            end else begin
               prod_in[i*KD+j] = '0;
            end
         end
      end
   end

   logic signed [PROD_BITS-1:0]              p_prod_ff [TAPS];
   logic [RB-1:0]                            p_row_ff;
   logic [v2dconv_pkg::OUT_COL_BITS-1:0]     p_col_ff;
   logic                                     p_last_ff;

   always_ff @(posedge clock) begin
      if (s1_adv && s1_hit) begin
         p_prod_ff <= prod_in;
         p_row_ff  <= s1_row_ff - RB'(kh_eff - 2'd1);
         p_col_ff  <= OCB'(s1_col_ff - COL_BITS'(kw_eff - 2'd1));
         p_last_ff <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Sum the products into the output register
   // ---------------------------------------------------------------------
   logic signed [VB-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < TAPS; k++) begin
         sum_in = sum_in + VB'(p_prod_ff[k]);
      end
   end

   logic signed [VB-1:0]                 out_value_ff;
   logic [RB-1:0]                        out_row_ff;
   logic [v2dconv_pkg::OUT_COL_BITS-1:0] out_col_ff;
   logic                                 out_last_ff;

   always_ff @(posedge clock) begin
      if (p_adv) begin
         out_value_ff <= sum_in;
         out_row_ff   <= p_row_ff;
         out_col_ff   <= p_col_ff;
         out_last_ff  <= p_last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_out_col     = out_col_ff;
   assign rsp_last_result = out_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Reset leaves the raster counters at the frame origin.
   assert property (@(posedge clock) reset |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters not cleared by reset");

   // The last sample of a frame restarts both counters.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_sample) |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters not restarted after last sample");

   // A blocked product stage keeps its transaction.
   assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && out_valid_ff && !rsp_ready) |=>
         (p_valid_ff && $stable(p_row_ff) && $stable(p_col_ff) && $stable(p_last_ff)))
      else $error("product stage lost a transaction under stall");

endmodule

>>> tb/valid_2d_convolution_tb.sv
// Self-checking testbench for the valid-region 2D convolution block.
`timescale 1ns / 1ps

module valid_2d_convolution_tb;

   localparam int KERNEL_DIM       = v2dconv_pkg::KERNEL_DIM;
   localparam int COEF_BITS        = v2dconv_pkg::COEF_BITS;
   localparam int VALUE_BITS       = v2dconv_pkg::VALUE_BITS;
   localparam int ROW_BITS         = v2dconv_pkg::ROW_BITS;
   localparam int OUT_COL_BITS     = v2dconv_pkg::OUT_COL_BITS;
   localparam int KSIZE_BITS       = v2dconv_pkg::KSIZE_BITS;
   localparam int ROW_LEN_BITS     = v2dconv_pkg::ROW_LEN_BITS;
   localparam int CSR_DATA_BITS    = v2dconv_pkg::CSR_DATA_BITS;
   localparam int CSR_INDEX_BITS   = v2dconv_pkg::CSR_INDEX_BITS;

   localparam int SAMPLE_WIDTH     = 16;
   localparam int LINE_LENGTH      = 1024;
   localparam int HALF_PERIOD      = 2;
   localparam int TAIL_CYCLES      = 8;        // pipeline is three stages deep; allow margin
   localparam int LONG_HOLD_CYCLES = 300;      // long enough to back the block up to its input
   localparam int TIMEOUT_NS       = 10_000_000;
   localparam int MAX_REPORTS      = 10;

   // One expected output transaction.
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [ROW_BITS-1:0]          row;
      logic [OUT_COL_BITS-1:0]      col;
      logic                         last;
   } window_sum_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_sample = '0;
   logic                           req_last_sample = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic signed [VALUE_BITS-1:0]   rsp_value;
   logic [ROW_BITS-1:0]            rsp_out_row;
   logic [OUT_COL_BITS-1:0]        rsp_out_col;
   logic                           rsp_last_result;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CSR_INDEX_BITS-1:0]      csr_index = '0;
   logic [CSR_DATA_BITS-1:0]       csr_wdata = '0;

   // Idling controls, set by the test tasks.
   bit sender_idles   = 1'b0;
   bit receiver_idles = 1'b0;
   int hold_requests  = 0;
   int failure_count  = 0;

   // Expected window sums, oldest first.
   window_sum_type expected_sums[$];

   // Predictor state: register copies, line stores, window and raster counters.
   logic [KSIZE_BITS-1:0]          cfg_height;
   logic [KSIZE_BITS-1:0]          cfg_width;
   logic [ROW_LEN_BITS-1:0]        cfg_row_len;
   v2dconv_pkg::kernel_row_type    cfg_kernel [0:KERNEL_DIM-1];
   logic signed [SAMPLE_WIDTH-1:0] line_mem [0:1][0:LINE_LENGTH-1];
   logic signed [SAMPLE_WIDTH-1:0] win [0:KERNEL_DIM-1][0:KERNEL_DIM-1];
   int unsigned                    col_idx;
   logic [ROW_BITS-1:0]            row_idx;

   valid_2d_convolution #(
      .MAX_ROW_LENGTH (LINE_LENGTH),
      .SAMPLE_BITS    (SAMPLE_WIDTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_result (rsp_last_result),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Kernel and row sizes as the block applies them: zero counts as one,
   // an over-long row saturates at the line store length.
   function automatic int eff_height();
      return (cfg_height == '0) ? 1 : int'(cfg_height);
   endfunction

   function automatic int eff_width();
      return (cfg_width == '0) ? 1 : int'(cfg_width);
   endfunction

   function automatic int eff_row_len();
      if (cfg_row_len == '0)
         return 1;
      if (int'(cfg_row_len) > LINE_LENGTH)
         return LINE_LENGTH;
      return int'(cfg_row_len);
   endfunction

   task automatic reset_predictor();
      cfg_height  = v2dconv_pkg::KSIZE_RESET;
      cfg_width   = v2dconv_pkg::KSIZE_RESET;
      cfg_row_len = v2dconv_pkg::ROW_LEN_RESET;
      for (int r = 0; r < KERNEL_DIM; r++) begin
         cfg_kernel[r] = '0;
         for (int q = 0; q < KERNEL_DIM; q++)
            win[r][q] = '0;
      end
      for (int c = 0; c < LINE_LENGTH; c++) begin
         line_mem[0][c] = '0;
         line_mem[1][c] = '0;
      end
      col_idx = 0;
      row_idx = '0;
   endtask

   task automatic apply_register(input v2dconv_pkg::csr_index_type idx,
                                 input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         v2dconv_pkg::CSR_KERNEL_HEIGHT: cfg_height    = data[KSIZE_BITS-1:0];
         v2dconv_pkg::CSR_KERNEL_WIDTH:  cfg_width     = data[KSIZE_BITS-1:0];
         v2dconv_pkg::CSR_ROW_LENGTH:    cfg_row_len   = data[ROW_LEN_BITS-1:0];
         v2dconv_pkg::CSR_KERNEL_ROW0:   cfg_kernel[0] = data;
         v2dconv_pkg::CSR_KERNEL_ROW1:   cfg_kernel[1] = data;
         v2dconv_pkg::CSR_KERNEL_ROW2:   cfg_kernel[2] = data;
         default: ;
      endcase
   endtask

   // Advance the window by one sample and queue the sum it yields, if any.
   task automatic convolve_sample(input logic signed [SAMPLE_WIDTH-1:0] sample, input logic last);
      logic signed [SAMPLE_WIDTH-1:0] fresh [0:KERNEL_DIM-1];
      logic signed [COEF_BITS-1:0]    coef;
      longint                         acc;
      window_sum_type                 sum;
      int                             kh;
      int                             kw;
      int                             rl;
      int unsigned                    c;
      kh = eff_height();
      kw = eff_width();
      rl = eff_row_len();
      c  = col_idx;
      // new column: oldest stored row on top, incoming sample at the bottom
      fresh[0] = line_mem[1][c];
      fresh[1] = line_mem[0][c];
      fresh[2] = sample;
      line_mem[1][c] = line_mem[0][c];
      line_mem[0][c] = sample;
      for (int r = 0; r < KERNEL_DIM; r++) begin
         for (int q = 0; q < KERNEL_DIM - 1; q++)
            win[r][q] = win[r][q+1];
         win[r][KERNEL_DIM-1] = fresh[r];
      end
      if (row_idx >= kh - 1 && c >= kw - 1) begin
         acc = 0;
         for (int x = 0; x < kh; x++) begin
            for (int y = 0; y < kw; y++) begin
               coef = cfg_kernel[x][COEF_BITS*y +: COEF_BITS];
               acc += longint'(coef) * longint'(win[KERNEL_DIM-kh+x][KERNEL_DIM-kw+y]);
            end
         end
         sum.value = acc[VALUE_BITS-1:0];
         sum.row   = row_idx - ROW_BITS'(kh - 1);
         sum.col   = OUT_COL_BITS'(c - (kw - 1));
         sum.last  = last;
         expected_sums.push_back(sum);
      end
      if (last) begin
         col_idx = 0;
         row_idx = '0;
      end else if (c + 1 >= rl) begin
         col_idx = 0;
         row_idx = row_idx + 1'b1;
      end else begin
         col_idx = c + 1;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      if (r < 95)
         return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // Bias towards the two extremes so that full-scale products turn up often.
   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   function automatic v2dconv_pkg::kernel_row_type random_kernel_row();
      v2dconv_pkg::kernel_row_type k;
      for (int j = 0; j < KERNEL_DIM; j++) begin
         case ($urandom_range(0, 5))
            0:       k[COEF_BITS*j +: COEF_BITS] = 16'h8000;
            1:       k[COEF_BITS*j +: COEF_BITS] = 16'h7FFF;
            2:       k[COEF_BITS*j +: COEF_BITS] = 16'h1000;      // unity in Q4.12
            3:       k[COEF_BITS*j +: COEF_BITS] = COEF_BITS'($urandom_range(0, 31));
            default: k[COEF_BITS*j +: COEF_BITS] = COEF_BITS'($urandom);
         endcase
      end
      return k;
   endfunction

   // Short rows most of the time; zero, rows shorter than the kernel and a
   // few longer rows now and then.
   function automatic int random_row_length();
      case ($urandom_range(0, 19))
         0:       return 0;
         1:       return $urandom_range(1, 2);
         2:       return $urandom_range(17, 48);
         default: return $urandom_range(3, 16);
      endcase
   endfunction

   // Present one sample and hold it until the block takes it. Valid stays
   // high into the next call unless a gap is drawn.
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] sample, input logic last);
      int gap;
      req_valid       <= 1'b1;
      req_sample      <= sample;
      req_last_sample <= last;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      convolve_sample(sample, last);
      gap = 0;
      if (sender_idles && $urandom_range(0, 99) < 30)
         gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Register write; csr_valid is left high so back-to-back writes do not
   // drop it. The caller lowers it after the last write.
   task automatic write_csr(input v2dconv_pkg::csr_index_type idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      apply_register(idx, data);
   endtask

   task automatic set_kernel(input int height, input int width, input int length,
                             input v2dconv_pkg::kernel_row_type k0,
                             input v2dconv_pkg::kernel_row_type k1,
                             input v2dconv_pkg::kernel_row_type k2);
      write_csr(v2dconv_pkg::CSR_KERNEL_HEIGHT, CSR_DATA_BITS'(height));
      write_csr(v2dconv_pkg::CSR_KERNEL_WIDTH,  CSR_DATA_BITS'(width));
      write_csr(v2dconv_pkg::CSR_ROW_LENGTH,    CSR_DATA_BITS'(length));
      write_csr(v2dconv_pkg::CSR_KERNEL_ROW0,   k0);
      write_csr(v2dconv_pkg::CSR_KERNEL_ROW1,   k1);
      write_csr(v2dconv_pkg::CSR_KERNEL_ROW2,   k2);
      csr_valid <= 1'b0;
   endtask

   // Stop offering samples, wait for every expected result, then let the
   // pipeline flush any sample that yields no result.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_sums.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(input int length);
      for (int i = 0; i < length; i++)
         send_sample(random_sample(), i == length - 1);
   endtask

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   task automatic report_failure(input string msg);
      failure_count++;
      if (failure_count <= MAX_REPORTS)
         $display("[%0t] %s", $time, msg);
   endtask

   task automatic check_window_sum();
      window_sum_type want;
      if (expected_sums.size() == 0) begin
         report_failure($sformatf("unexpected result value=%0d row=%0d col=%0d last=%0b",
                                  rsp_value, rsp_out_row, rsp_out_col, rsp_last_result));
      end else begin
         want = expected_sums.pop_front();
         if (rsp_value !== want.value || rsp_out_row !== want.row ||
             rsp_out_col !== want.col || rsp_last_result !== want.last)
            report_failure({$sformatf("result mismatch: expected value=%0d row=%0d col=%0d last=%0b",
                                      $signed(want.value), want.row, want.col, want.last),
                            $sformatf(", got value=%0d row=%0d col=%0d last=%0b",
                                      rsp_value, rsp_out_row, rsp_out_col, rsp_last_result)});
      end
   endtask

   // Result side: check each transaction, then decide the next ready. A long
   // hold-off requested by a test is counted down here, cycle by cycle.
   always @(posedge clock) begin : result_side
      int stall_left;
      int hold_served;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         check_window_sum();
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         stall_left  = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 99) < 30) begin
         stall_left = idle_length() - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset defaults: 3x3 kernel over 1024-sample rows, so a four-sample
   // frame ends inside row 0 and must produce nothing.
   task automatic test_reset_defaults();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd1,   1'b1);
      drain_pipeline();
   endtask

   // Full-scale window: every coefficient and every sample at the most
   // negative value gives the largest positive sum.
   task automatic test_extreme_values();
      set_kernel(3, 3, 3, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
      for (int i = 0; i < 9; i++)
         send_sample(16'sh8000, i == 8);
      drain_pipeline();
   endtask

   // Zero sizes count as one, a zero row length as one, and a row shorter
   // than the kernel never yields a result.
   task automatic test_degenerate_sizes();
      set_kernel(0, 2, 3, 48'h7FFF_8000_7FFF, random_kernel_row(), random_kernel_row());
      send_frame(3);
      drain_pipeline();
      set_kernel(2, 0, 0, random_kernel_row(), random_kernel_row(), random_kernel_row());
      send_frame(3);
      drain_pipeline();
      set_kernel(3, 3, 2, random_kernel_row(), random_kernel_row(), random_kernel_row());
      send_frame(4);
      drain_pipeline();
   endtask

   // Pause mid-frame until every result is out, then swap coefficients and
   // shorten the row: both apply at once, and the column past the new row
   // end wraps on the following sample.
   task automatic test_mid_frame_change();
      set_kernel(1, 2, 6, 48'h0000_7FFF_1000, random_kernel_row(), random_kernel_row());
      for (int i = 0; i < 3; i++)
         send_sample(random_sample(), 1'b0);
      drain_pipeline();
      write_csr(v2dconv_pkg::CSR_KERNEL_ROW0, 48'h0000_8000_7FFF);
      write_csr(v2dconv_pkg::CSR_ROW_LENGTH, CSR_DATA_BITS'(2));
      csr_valid <= 1'b0;
      send_frame(3);
      drain_pipeline();
   endtask

   // Hold the result side off for a long stretch while samples keep coming,
   // so the block fills and drops req_ready.
   task automatic test_output_stall();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      set_kernel(2, 2, 6, random_kernel_row(), random_kernel_row(), random_kernel_row());
      hold_requests++;
      send_frame(48);
      drain_pipeline();
   endtask

   // Row length beyond the line store saturates at 1024; reach the last
   // output column and carry on into the next row.
   task automatic test_long_rows();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      set_kernel(1, 1, 2047, random_kernel_row(), random_kernel_row(), random_kernel_row());
      send_frame(LINE_LENGTH + 4);
      drain_pipeline();
   endtask

   // Random kernels and row lengths; mostly whole frames, some cut short by
   // an early last sample. Idling on either side changes per frame.
   task automatic test_random_frames(input int budget);
      int sent;
      int frame_len;
      int mode;
      sent = 0;
      while (sent < budget) begin
         if (sent == 0 || $urandom_range(0, 2) == 0) begin
            drain_pipeline();
            set_kernel($urandom_range(0, 3), $urandom_range(0, 3), random_row_length(),
                       random_kernel_row(), random_kernel_row(), random_kernel_row());
         end
         mode           = $urandom_range(0, 3);
         sender_idles   = mode[0];
         receiver_idles = mode[1];
         frame_len = (eff_height() + $urandom_range(0, 3)) * eff_row_len();
         if ($urandom_range(0, 9) == 0)
            frame_len = $urandom_range(1, frame_len);
         send_frame(frame_len);
         sent += frame_len;
      end
      drain_pipeline();
   endtask

   initial begin
      reset_predictor();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_extreme_values();
      test_degenerate_sizes();
      test_mid_frame_change();
      test_output_stall();
      test_long_rows();
      test_random_frames(880);
      if (failure_count == 0)
         $display("valid_2d_convolution_tb OK");
      else
         $display("valid_2d_convolution_tb NOT OK");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("valid_2d_convolution_tb NOT OK");
      $finish;
   end

endmodule
